@@ rtl/core/krt_pkg.sv @@
package krt_pkg;

  // field widths of one record
  localparam int KEY_W       = 32;
  localparam int YEAR_W      = 16;
  localparam int CODE_W      = 16;
  localparam int GRADE_W     = 7;
  localparam int MAX_COURSES = 3;

  // bit positions inside tdata, shared by both channels
  localparam int KEY_LSB   = 0;
  localparam int YEAR_LSB  = KEY_LSB + KEY_W;
  localparam int CODE_LSB  = YEAR_LSB + YEAR_W;
  localparam int GRADE_LSB = CODE_LSB + MAX_COURSES * CODE_W;
  localparam int CNT_LSB   = GRADE_LSB + MAX_COURSES * GRADE_W;

  localparam logic [GRADE_W-1:0] GRADE_MAX = 7'd100;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_DEL    = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_DUMP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

endpackage

@@ rtl/core/keyed_record_table.sv @@
// channel | dir | handshake            | tdata (low bit up)                      | tuser  | tlast
// in_     | in  | in_tvalid/in_tready  | key, year, code a..c, grade a..c        | func   | -
// out_    | out | out_tvalid/out_tready| key, year, codes, grades, used, is_full | status | last
//
// add, and every answer that needs no search, passes through S_RESP to the output register
// lookup scans from the first entry, one record memory read per cycle, to a match or the last entry
// delete then moves each later record down one place through the same read port to close the gap
// dump gives its results in table order, each a memory read then an output load
// reset clears the used count and the control; the record memory is not cleared
// a stalled output holds the sequencer, the next item is taken only when it is idle
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int COURSES  = 3,
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int IN_BITS = CNT_LSB,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = CNT_LSB + CW + 1,
  localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // key_id, year_in, course_a_in, course_b_in, course_c_in, grade_a_in, grade_b_in,
  // grade_c_in, zero fill
  input  logic [IN_W-1:0]  in_tdata,
  // func
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // key_out, year_out, course_a_out, course_b_out, course_c_out, grade_a_out,
  // grade_b_out, grade_c_out, used_count, is_full, zero fill
  output logic [OUT_W-1:0] out_tdata,
  // status
  output logic [1:0]       out_tuser,
  // last_of_run
  output logic             out_tlast
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef struct packed {
    logic [KEY_W-1:0]                 key;
    logic [YEAR_W-1:0]                year;
    logic [COURSES-1:0][CODE_W-1:0]   code;
    logic [COURSES-1:0][GRADE_W-1:0]  grade;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_t;

  // record memory, one record per entry, kept in table order
  rec_t rec_mem [CAPACITY];

  state_t           state_r;
  func_t            func_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    ptr_r;       // next position to read
  logic             rd_vld_r;    // rd_data_r holds the entry at rd_pos_r
  logic [CW-1:0]    rd_pos_r;
  rec_t             rd_data_r;
  rec_t             res_rec_r;   // record of a single-result answer
  status_t          res_st_r;

  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic [1:0]       out_tuser_r;
  logic             out_tlast_r;

  logic             in_acc;
  func_t            in_func;
  rec_t             in_rec;
  logic             out_free;
  logic             tbl_full;
  logic [CW-1:0]    last_pos;
  logic             hit;
  logic             at_end;
  logic             issue;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  rec_t             mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  logic             out_load;
  rec_t             out_rec;
  status_t          out_st;
  logic             out_last;
  logic [OUT_W-1:0] out_data_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_func   = func_t'(in_tuser);
  assign out_free  = !out_tvalid_r || out_tready;
  assign tbl_full  = (count_r == CW'(CAPACITY));
  assign last_pos  = count_r - CW'(1);

  // unpack the incoming record, grades saturate at the top mark
  always_comb begin
    logic [GRADE_W-1:0] g;
    g            = '0;
    in_rec       = '0;
    in_rec.key   = in_tdata[KEY_LSB +: KEY_W];
    in_rec.year  = in_tdata[YEAR_LSB +: YEAR_W];
    for (int c = 0; c < COURSES; c++) begin
      g               = in_tdata[GRADE_LSB + c * GRADE_W +: GRADE_W];
      in_rec.code[c]  = in_tdata[CODE_LSB + c * CODE_W +: CODE_W];
      in_rec.grade[c] = (g > GRADE_MAX) ? GRADE_MAX : g;
    end
  end

  // search and shift share the read pipeline
  assign hit    = rd_vld_r && (rd_data_r.key == key_r);
  assign at_end = rd_vld_r && (rd_pos_r == last_pos);
  assign issue  = (ptr_r < count_r) && !((state_r == S_SCAN) && hit);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = in_rec;
    mem_re    = 1'b0;
    mem_raddr = ptr_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        mem_we = in_acc && (in_func == FUNC_ADD) && !tbl_full;
      end
      S_SCAN: begin
        mem_re = issue;
      end
      S_SHIFT: begin
        // entry at rd_pos_r moves down one place
        mem_re    = issue;
        mem_we    = rd_vld_r;
        mem_waddr = AW'(rd_pos_r - CW'(1));
        mem_wdata = rd_data_r;
      end
      S_DUMP_RD: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rec_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= rec_mem[mem_raddr];
    end
  end

  // result selection for the output register
  always_comb begin
    out_load = 1'b0;
    out_rec  = res_rec_r;
    out_st   = res_st_r;
    out_last = 1'b1;
    unique case (state_r)
      S_RESP: begin
        out_load = out_free;
      end
      S_DUMP_OUT: begin
        out_load = out_free;
        out_rec  = rd_data_r;
        out_st   = ST_OK;
        out_last = (ptr_r == last_pos);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[KEY_LSB +: KEY_W]   = out_rec.key;
    out_data_nxt[YEAR_LSB +: YEAR_W] = out_rec.year;
    for (int c = 0; c < COURSES; c++) begin
      out_data_nxt[CODE_LSB + c * CODE_W +: CODE_W]    = out_rec.code[c];
      out_data_nxt[GRADE_LSB + c * GRADE_W +: GRADE_W] = out_rec.grade[c];
    end
    out_data_nxt[CNT_LSB +: CW] = count_r;
    out_data_nxt[CNT_LSB + CW]  = tbl_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      ptr_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_vld_r <= mem_re;
      if (mem_re) begin
        rd_pos_r <= ptr_r;
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= out_data_nxt;
        out_tuser_r  <= out_st;
        out_tlast_r  <= out_last;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          ptr_r <= '0;
          if (in_acc) begin
            func_r <= in_func;
            key_r  <= in_rec.key;
            if (in_func == FUNC_ADD) begin
              if (tbl_full) begin
                res_st_r  <= ST_FULL;
                res_rec_r <= '0;
              end else begin
                res_st_r  <= ST_OK;
                res_rec_r <= in_rec;
                count_r   <= count_r + CW'(1);
              end
              state_r <= S_RESP;
            end else if (count_r == '0) begin
              res_st_r  <= ST_EMPTY;
              res_rec_r <= '0;
              state_r   <= S_RESP;
            end else if (in_func == FUNC_DUMP) begin
              state_r <= S_DUMP_RD;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end
          priority if (hit) begin
            res_st_r  <= ST_OK;
            res_rec_r <= rd_data_r;
            if (func_r == FUNC_DEL) begin
              if (rd_pos_r == last_pos) begin
                // oldest match is the newest record, nothing to move
                count_r <= last_pos;
                state_r <= S_RESP;
              end else begin
                ptr_r   <= rd_pos_r + CW'(1);
                state_r <= S_SHIFT;
              end
            end else begin
              state_r <= S_RESP;
            end
          end else if (at_end) begin
            res_st_r  <= ST_NOT_FOUND;
            res_rec_r <= '0;
            state_r   <= S_RESP;
          end else begin
          end
        end
        S_SHIFT: begin
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end
          if (at_end) begin
            count_r <= last_pos;
            state_r <= S_RESP;
          end
        end
        S_DUMP_RD: begin
          state_r <= S_DUMP_OUT;
        end
        S_DUMP_OUT: begin
          if (out_free) begin
            if (ptr_r == last_pos) begin
              state_r <= S_IDLE;
            end else begin
              ptr_r   <= ptr_r + CW'(1);
              state_r <= S_DUMP_RD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ rtl/core/krt_checker.sv @@
module krt_checker
  import krt_pkg::*;
#(
  parameter int CAPACITY = 16,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int OUT_BITS = CNT_LSB + CW + 1,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [1:0]       out_tuser,
  input logic             out_tlast
);

  logic          in_acc;
  logic          out_acc;
  logic [CW-1:0] used;
  logic [1:0]    pend_r;     // items accepted whose run is not yet complete
  logic          mid_run_r;  // previous result was not the last of its run
  logic [CW-1:0] prev_used_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign used    = out_tdata[CNT_LSB +: CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      mid_run_r <= 1'b0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc && out_tlast);
      if (out_acc) begin
        mid_run_r   <= !out_tlast;
        prev_used_r <= used;
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (used <= CW'(CAPACITY)) &&
                   (out_tdata[CNT_LSB + CW] == (used == CW'(CAPACITY))))
    else $error("used count or full flag inconsistent");

  a_no_record_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |->
      out_tlast && (out_tdata[CNT_LSB-1:0] == '0))
    else $error("error result carries record data or is not last");

  a_run_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && mid_run_r) |-> (used == prev_used_r) && (out_tuser == ST_OK))
    else $error("dump run changed count or status");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc |-> pend_r != 2'd0) and (in_acc |-> pend_r != 2'd2))
    else $error("result without an item or too many items in flight");

endmodule

bind keyed_record_table krt_checker #(.CAPACITY(CAPACITY)) u_krt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
